@@ hw/rtl/vsa_pkg.sv @@
package vsa_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int ANGLE_WIDTH     = 16;
	localparam int CORDIC_STAGES   = 16;

	localparam int TRIG_FRAC = 30;
	localparam int TRIG_W    = 34;
	localparam int ZW        = 33;
	localparam int PQ_W      = COMPONENT_WIDTH + 2;
	localparam int PROD1_W   = COMPONENT_WIDTH + TRIG_W;
	localparam int PROD2_W   = PQ_W + TRIG_W;
	localparam int ATAN_ENTRIES = 24;

	localparam int LATENCY = CORDIC_STAGES + 6;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = TRIG_W'(652032874);

	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] vec_x;
		logic signed [COMPONENT_WIDTH-1:0] vec_y;
		logic [ANGLE_WIDTH-1:0]            split_angle;
	} operand_t;

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] along_x;
		logic signed [COMPONENT_WIDTH-1:0] along_y;
		logic signed [COMPONENT_WIDTH-1:0] across_x;
		logic signed [COMPONENT_WIDTH-1:0] across_y;
	} result_t;

	typedef struct packed {
		logic signed [COMPONENT_WIDTH-1:0] vec_x;
		logic signed [COMPONENT_WIDTH-1:0] vec_y;
	} vec_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

	typedef struct packed {
		logic signed [PQ_W-1:0] p;
		logic signed [PQ_W-1:0] q;
	} proj_t;

endpackage

@@ hw/rtl/vsa_cordic.sv @@
module vsa_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  vsa_pkg::operand_t operand,
	output logic            trig_valid,
	output vsa_pkg::trig_t  trig,
	output vsa_pkg::vec_t   vec
);

	localparam int N = vsa_pkg::CORDIC_STAGES;
	localparam int TW = vsa_pkg::TRIG_W;
	localparam int ZW = vsa_pkg::ZW;

	logic signed [TW-1:0] x_s [0:N];
	logic signed [TW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N-1];
	logic                 flip_s [0:N];
	vsa_pkg::vec_t        vec_s [0:N];
	logic                 valid_s [0:N];

	logic [31:0] turn;
	logic        flip;

	vsa_pkg::trig_t trig_sn;
	vsa_pkg::vec_t  vec_sn;
	logic           valid_sn;

	// quadrant fold to [-90, 90) degrees
	assign turn = {operand.split_angle, {(32 - vsa_pkg::ANGLE_WIDTH){1'b0}}};
	assign flip = turn[31] ^ turn[30];

	always_ff @(posedge clk) begin
		x_s[0]    <= vsa_pkg::CORDIC_GAIN_INV;
		y_s[0]    <= '0;
		z_s[0]    <= ZW'($signed({turn[31] ^ flip, turn[30:0]}));
		flip_s[0] <= flip;
		vec_s[0]  <= '{vec_x: operand.vec_x, vec_y: operand.vec_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= valid;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		logic signed [TW-1:0] dx;
		logic signed [TW-1:0] dy;
		logic                 neg;

		assign dx  = x_s[k] >>> k;
		assign dy  = y_s[k] >>> k;
		assign neg = z_s[k][ZW-1];

		always_ff @(posedge clk) begin
			x_s[k+1]    <= neg ? x_s[k] + dy : x_s[k] - dy;
			y_s[k+1]    <= neg ? y_s[k] - dx : y_s[k] + dx;
			flip_s[k+1] <= flip_s[k];
			vec_s[k+1]  <= vec_s[k];
		end

		if (k < N - 1) begin : g_z
			logic signed [ZW-1:0] step;

			assign step = $signed(ZW'(vsa_pkg::ATAN_TURNS[k]));

			always_ff @(posedge clk) begin
				z_s[k+1] <= neg ? z_s[k] + step : z_s[k] - step;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end
	end

	// undo the quadrant fold
	always_ff @(posedge clk) begin
		trig_sn.c <= flip_s[N] ? -x_s[N] : x_s[N];
		trig_sn.s <= flip_s[N] ? -y_s[N] : y_s[N];
		vec_sn    <= vec_s[N];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else begin
			valid_sn <= valid_s[N];
		end
	end

	assign trig_valid = valid_sn;
	assign trig       = trig_sn;
	assign vec        = vec_sn;

endmodule

@@ hw/rtl/vsa_project.sv @@
module vsa_project (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  vsa_pkg::trig_t trig,
	input  vsa_pkg::vec_t  vec,
	output logic           proj_valid,
	output vsa_pkg::proj_t proj,
	output vsa_pkg::trig_t proj_trig
);

	localparam int PW = vsa_pkg::PROD1_W;
	localparam int SW = PW + 2;
	localparam int F  = vsa_pkg::TRIG_FRAC;
	localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (F - 1));

	logic signed [PW-1:0] xc_s1, ys_s1, yc_s1, xs_s1;
	vsa_pkg::trig_t       trig_s1, trig_s2;
	vsa_pkg::proj_t       proj_s2;
	logic                 valid_s1, valid_s2;

	logic signed [SW-1:0] p_sum, q_sum;

	always_ff @(posedge clk) begin
		xc_s1   <= PW'(vec.vec_x * trig.c);
		ys_s1   <= PW'(vec.vec_y * trig.s);
		yc_s1   <= PW'(vec.vec_y * trig.c);
		xs_s1   <= PW'(vec.vec_x * trig.s);
		trig_s1 <= trig;
	end

	assign p_sum = SW'(xc_s1) + SW'(ys_s1) + HALF;
	assign q_sum = SW'(yc_s1) - SW'(xs_s1) + HALF;

	always_ff @(posedge clk) begin
		proj_s2.p <= p_sum[F + vsa_pkg::PQ_W - 1:F];
		proj_s2.q <= q_sum[F + vsa_pkg::PQ_W - 1:F];
		trig_s2   <= trig_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	assign proj_valid = valid_s2;
	assign proj       = proj_s2;
	assign proj_trig  = trig_s2;

endmodule

@@ hw/rtl/vsa_scale.sv @@
module vsa_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  vsa_pkg::proj_t   proj,
	input  vsa_pkg::trig_t   trig,
	output logic             result_valid,
	output vsa_pkg::result_t result
);

	localparam int PW = vsa_pkg::PROD2_W;
	localparam int CW = vsa_pkg::COMPONENT_WIDTH;
	localparam int F  = vsa_pkg::TRIG_FRAC;
	localparam int RW = PW + 1 - F;

	function automatic logic signed [CW-1:0] round_sat(input logic signed [PW-1:0] v);
		logic signed [PW:0]   sum;
		logic signed [RW-1:0] r;
		logic signed [RW-1:0] hi;
		logic signed [RW-1:0] lo;
		sum = $signed({v[PW-1], v}) + $signed((PW + 1)'(64'd1 << (F - 1)));
		r   = sum[PW:F];
		hi  = $signed({{(RW - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
		lo  = ~hi;
		if (r > hi) begin
			r = hi;
		end else if (r < lo) begin
			r = lo;
		end
		return r[CW-1:0];
	endfunction

	logic signed [vsa_pkg::TRIG_W-1:0] s_neg;
	logic signed [PW-1:0] pc_s1, ps_s1, qs_s1, qc_s1;
	vsa_pkg::result_t     result_s2;
	logic                 valid_s1, valid_s2;

	assign s_neg = -trig.s;

	always_ff @(posedge clk) begin
		pc_s1 <= PW'(proj.p * trig.c);
		ps_s1 <= PW'(proj.p * trig.s);
		qs_s1 <= PW'(proj.q * s_neg);
		qc_s1 <= PW'(proj.q * trig.c);
	end

	always_ff @(posedge clk) begin
		result_s2.along_x  <= round_sat(pc_s1);
		result_s2.along_y  <= round_sat(ps_s1);
		result_s2.across_x <= round_sat(qs_s1);
		result_s2.across_y <= round_sat(qc_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

@@ hw/rtl/vector_split_along_angle_top.sv @@
// valid path: cordic input, rotation and fold regs, then project and scale s1, s2
// throughput: one item per cycle, busy stays low, set by the fully pipelined
// cordic rotation stages and the two registered multiply stages
// the receiver cannot stall: each result shows on result for one cycle only
// reset: arst_n low clears all valid bits at once, items in flight are dropped
module vector_split_along_angle_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vsa_pkg::operand_t operand,
	output logic              result_valid,
	output vsa_pkg::result_t  result
);

	logic           trig_valid;
	vsa_pkg::trig_t trig;
	vsa_pkg::vec_t  vec;
	logic           proj_valid;
	vsa_pkg::proj_t proj;
	vsa_pkg::trig_t proj_trig;

	assign busy = 1'b0;

	vsa_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (start & ~busy),
		.operand    (operand),
		.trig_valid (trig_valid),
		.trig       (trig),
		.vec        (vec)
	);

	vsa_project u_project (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (trig_valid),
		.trig       (trig),
		.vec        (vec),
		.proj_valid (proj_valid),
		.proj       (proj),
		.proj_trig  (proj_trig)
	);

	vsa_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (proj_valid),
		.proj         (proj),
		.trig         (proj_trig),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ hw/rtl/vsa_checker.sv @@
module vsa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input vsa_pkg::operand_t operand,
	input logic              result_valid,
	input vsa_pkg::result_t  result
);

	localparam int LAT = vsa_pkg::LATENCY;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT result_valid)
		else $error("item result missing");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LAT))
		else $error("result without item");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operand.vec_x == '0 && operand.vec_y == '0)
		|-> ##LAT (result == '0))
		else $error("zero vector gave nonzero result");

endmodule

bind vector_split_along_angle_top vsa_checker u_vsa_checker (.*);
